FILE: rtl/srwcc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sensor reply word CRC checker.
// No dependencies; imported by srwcc_crc8 and the top level.
package srwcc_pkg;

  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_TOP_BIT = 8'h80;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FIRST  = 2'd1,
    ST_BAD_SECOND = 2'd2
  } status_e;

  // Position of the next expected reply byte; idle waits for a start flag.
  typedef enum logic [5:0] {
    POS_IDLE  = 6'b000001,
    POS_LOW1  = 6'b000010,
    POS_CRC1  = 6'b000100,
    POS_HIGH2 = 6'b001000,
    POS_LOW2  = 6'b010000,
    POS_CRC2  = 6'b100000
  } pos_e;

endpackage

FILE: rtl/sensor_reply_word_crc_checker_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// input    | in        | in_valid_i/in_stall_o | rx_byte_i, start_of_read_i
// result   | out       | out_valid_o/out_stall_i | co2_value_o, tvoc_value_o, status_o
// One byte per cycle is taken unless in_stall_o holds the input; the sixth byte of a
// reply passes through the input register, then the result register.
// Reset clears the byte position, CRC, error flag and stored good words.
// A stalled result holds the result register; the input register still drains
// bytes that produce no result. Depends on srwcc_pkg and srwcc_crc8.
module sensor_reply_word_crc_checker_top
  import srwcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        start_of_read_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] co2_value_o,
  output logic [15:0] tvoc_value_o,
  output logic [1:0]  status_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  logic        start_q;
  pos_e        pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_seed, crc_next;
  logic [7:0]  high_q, high_d;
  logic [15:0] pend1_q, pend1_d, pend2_q, pend2_d;
  logic        bad1_q, bad1_d;
  logic [15:0] good1_q, good1_d, good2_q, good2_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] co2_q, tvoc_q;
  status_e     status_q, status_d;
  logic        in_accept, has_result, advance, out_load;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign has_result = !start_q && (pos_q == POS_CRC2);
  assign advance    = in_valid_q && (!has_result || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign out_load   = advance && has_result;
  assign pos_eff    = start_q ? POS_IDLE : pos_q;

  assign crc_seed = (pos_eff == POS_IDLE || pos_eff == POS_HIGH2) ? CRC_INIT : crc_q;

  srwcc_crc8 u_crc8 (
    .crc_i  (crc_seed),
    .data_i (byte_q),
    .crc_o  (crc_next)
  );

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    high_d   = high_q;
    pend1_d  = pend1_q;
    pend2_d  = pend2_q;
    bad1_d   = bad1_q;
    good1_d  = good1_q;
    good2_d  = good2_q;
    status_d = ST_OK;
    if (advance && (start_q || pos_q != POS_IDLE)) begin
      unique case (pos_eff)
        POS_IDLE: begin
          crc_d  = crc_next;
          high_d = byte_q;
          pos_d  = POS_LOW1;
        end
        POS_LOW1: begin
          crc_d   = crc_next;
          pend1_d = {high_q, byte_q};
          pos_d   = POS_CRC1;
        end
        POS_CRC1: begin
          bad1_d = (crc_q != byte_q);
          crc_d  = CRC_INIT;
          pos_d  = POS_HIGH2;
        end
        POS_HIGH2: begin
          crc_d  = crc_next;
          high_d = byte_q;
          pos_d  = POS_LOW2;
        end
        POS_LOW2: begin
          crc_d   = crc_next;
          pend2_d = {high_q, byte_q};
          pos_d   = POS_CRC2;
        end
        POS_CRC2: begin
          priority if (bad1_q) begin
            status_d = ST_BAD_FIRST;
          end else if (crc_q != byte_q) begin
            status_d = ST_BAD_SECOND;
          end else begin
            status_d = ST_OK;
            good1_d  = pend1_q;
            good2_d  = pend2_q;
          end
          crc_d = CRC_INIT;
          pos_d = POS_IDLE;
        end
        default: begin
          pos_d = POS_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= POS_IDLE;
      crc_q       <= CRC_INIT;
      bad1_q      <= 1'b0;
      good1_q     <= 16'h0000;
      good2_q     <= 16'h0000;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      bad1_q      <= bad1_d;
      good1_q     <= good1_d;
      good2_q     <= good2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= rx_byte_i;
      start_q <= start_of_read_i;
    end
    high_q  <= high_d;
    pend1_q <= pend1_d;
    pend2_q <= pend2_d;
    if (out_load) begin
      co2_q    <= good1_d;
      tvoc_q   <= good2_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign co2_value_o  = co2_q;
  assign tvoc_value_o = tvoc_q;
  assign status_o     = status_q;

  a_pos_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(pos_q))
    else $error("byte position lost its one-hot code");

  a_result_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (pos_q == POS_IDLE) && out_valid_o)
    else $error("result transaction did not return to idle");

  a_ok_matches_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_d == ST_OK) |=>
      (co2_value_o == good1_q) && (tvoc_value_o == good2_q))
    else $error("good result does not match stored words");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule

FILE: rtl/srwcc_crc8.sv
`timescale 1ns / 1ps
// One-byte CRC-8 update, polynomial 0x31, MSB first, purely combinational.
// Depends on srwcc_pkg for the polynomial constants.
module srwcc_crc8
  import srwcc_pkg::*;
(
  input  logic [7:0] crc_i,
  input  logic [7:0] data_i,
  output logic [7:0] crc_o
);

  always_comb begin
    logic [7:0] r;
    r = crc_i ^ data_i;
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_TOP_BIT) != 8'h00) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    crc_o = r;
  end

endmodule

FILE: sim/tb_sensor_reply_word_crc_checker_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_reply_word_crc_checker_top: sends six-byte sensor replies,
// predicts each status/word result with its own CRC-8 word checker and compares in order.
// Depends on srwcc_pkg and the RTL of the top level.
module tb_sensor_reply_word_crc_checker_top;
  import srwcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned MAX_IDLE     = 18;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [15:0] co2;
    logic [15:0] tvoc;
    status_e     status;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        start_of_read_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] co2_value_o;
  logic [15:0] tvoc_value_o;
  logic [1:0]  status_o;

  reading_t    expected_readings[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  int unsigned stall_left  = 0;
  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;

  int unsigned rx_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  word_hi;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic        first_bad;
  logic [15:0] last_co2;
  logic [15:0] last_tvoc;

  sensor_reply_word_crc_checker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .start_of_read_i(start_of_read_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .co2_value_o    (co2_value_o),
    .tvoc_value_o   (tvoc_value_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** sensor_reply_word_crc_checker_top: FAILED **");
    $finish;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    int         k;
    r = crc ^ data;
    for (k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  task automatic predict_reply_byte(input logic [7:0] b, input logic sor);
    reading_t r;
    if (sor) begin
      rx_pos = 0;
    end else if (rx_pos == 0) begin
      return;
    end
    case (rx_pos)
      0, 3: begin
        crc_acc = crc8_step(CRC_INIT, b);
        word_hi = b;
      end
      1: begin
        crc_acc    = crc8_step(crc_acc, b);
        first_word = {word_hi, b};
      end
      2: begin
        first_bad = (crc_acc != b);
        crc_acc   = CRC_INIT;
      end
      4: begin
        crc_acc     = crc8_step(crc_acc, b);
        second_word = {word_hi, b};
      end
      default: begin
        if (first_bad) begin
          r.status = ST_BAD_FIRST;
        end else if (crc_acc != b) begin
          r.status = ST_BAD_SECOND;
        end else begin
          r.status  = ST_OK;
          last_co2  = first_word;
          last_tvoc = second_word;
        end
        r.co2  = last_co2;
        r.tvoc = last_tvoc;
        expected_readings.push_back(r);
        crc_acc = CRC_INIT;
      end
    endcase
    rx_pos = (rx_pos == 5) ? 0 : rx_pos + 1;
  endtask

  initial begin : result_stall
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i = 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin : result_monitor
    reading_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (rx_idle) stall_left = $urandom_range(0, MAX_IDLE);
        if (expected_readings.size() == 0) begin
          $display("%0t unexpected reading: co2 %h tvoc %h status %0d", $time,
                   co2_value_o, tvoc_value_o, status_o);
          fail_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (co2_value_o !== exp_r.co2) begin
            $display("%0t co2_value mismatch: expected %h actual %h", $time,
                     exp_r.co2, co2_value_o);
            fail_count++;
          end
          if (tvoc_value_o !== exp_r.tvoc) begin
            $display("%0t tvoc_value mismatch: expected %h actual %h", $time,
                     exp_r.tvoc, tvoc_value_o);
            fail_count++;
          end
          if (status_o !== exp_r.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     exp_r.status, status_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Leave valid high on return; settle, or the next call when it waits a gap, lowers it.
  task automatic send_byte(input logic [7:0] b, input logic sor);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    rx_byte_i       = b;
    start_of_read_i = sor;
    do @(posedge clk_i); while (in_stall_o);
    predict_reply_byte(b, sor);
    @(negedge clk_i);
  endtask

  task automatic send_reply(input logic [15:0] w1, input logic [15:0] w2,
                            input bit bad1, input bit bad2);
    logic [7:0] c1;
    logic [7:0] c2;
    c1 = word_crc(w1) ^ (bad1 ? 8'($urandom_range(1, 255)) : 8'h00);
    c2 = word_crc(w2) ^ (bad2 ? 8'($urandom_range(1, 255)) : 8'h00);
    send_byte(w1[15:8], 1'b1);
    send_byte(w1[7:0], 1'b0);
    send_byte(c1, 1'b0);
    send_byte(w2[15:8], 1'b0);
    send_byte(w2[7:0], 1'b0);
    send_byte(c2, 1'b0);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_crc_errors();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_reply(16'hFFFF, 16'h0000, 1'b1, 1'b0);
    send_reply(16'($urandom), 16'($urandom), 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_framing();
    send_byte(8'hA5, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_reply(16'h0000, 16'hFFFF, 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_input_backpressure();
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    hold_cycles = LONG_HOLD;
    repeat (10) send_reply(16'($urandom), 16'($urandom), 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_random_replies();
    int unsigned sent;
    int unsigned n;
    sent    = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 9))
        0: begin
          send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
          sent += 1;
        end
        1: begin
          n = $urandom_range(1, 5);
          send_byte(8'($urandom), 1'b1);
          repeat (n - 1) send_byte(8'($urandom), 1'b0);
          sent += n;
        end
        default: begin
          send_reply(16'($urandom), 16'($urandom),
                     $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
          sent += 6;
        end
      endcase
    end
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    rx_byte_i       = 8'h00;
    start_of_read_i = 1'b0;
    rx_pos          = 0;
    crc_acc         = CRC_INIT;
    word_hi         = 8'h00;
    first_word      = 16'h0000;
    second_word     = 16'h0000;
    first_bad       = 1'b0;
    last_co2        = 16'h0000;
    last_tvoc       = 16'h0000;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_crc_errors();
    test_framing();
    test_input_backpressure();
    test_random_replies();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("** sensor_reply_word_crc_checker_top: PASSED **");
    end else begin
      $display("** sensor_reply_word_crc_checker_top: FAILED **");
    end
    $finish;
  end

endmodule
